FILE: rtl/ios_pkg.sv
// Shared types and codes for the insertion-ordered set store.
// No dependencies; imported by insertion_ordered_set_store.
`default_nettype none

package ios_pkg;

    // Request field widths and stream packing
    localparam int OP_BITS    = 3;
    localparam int VALUE_BITS = 32;
    localparam int POS_BITS   = 4;
    localparam int COUNT_BITS = 5;
    localparam int TDATA_BITS = 40;

    typedef logic [OP_BITS-1:0] op_t;

    localparam op_t OP_ADD      = 3'd0;
    localparam op_t OP_CONTAINS = 3'd1;
    localparam op_t OP_REMOVE   = 3'd2;
    localparam op_t OP_GET      = 3'd3;
    localparam op_t OP_CLEAR    = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_SHIFT  = 5'b00100,
        ST_GET    = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/insertion_ordered_set_store.sv
// Insertion-ordered set store: add/contains/remove/get/clear, one entry compared per cycle.
// Sequence: clear, unused codes, invalid get and an empty store go straight to finish; get
//   reads the entry first; add/contains/remove scan entries until a hit or the last entry,
//   and a remove hit then shifts later entries down. A held result stalls the finish.
// Flow: one request in flight; the next is accepted once the result has loaded.
// Reset: rst_n async low clears sequencer, count and output valid; entry memory is not.
`default_nettype none

module insertion_ordered_set_store #(
    parameter int CAPACITY  = 16,
    parameter int ELEM_BITS = 32
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // [2:0] operation, [34:3] value, [38:35] position, [39] zero
    input  wire  [ios_pkg::TDATA_BITS-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // [0] ok, [32:1] element, [37:33] count, [38] full_reject, [39] zero
    output logic [ios_pkg::TDATA_BITS-1:0]  m_tdata
);
    import ios_pkg::*;

    localparam int EW = (ELEM_BITS < VALUE_BITS) ? ELEM_BITS : VALUE_BITS;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    state_t          state_reg, state_next;
    op_t             op_reg, op_next;
    logic [EW-1:0]   val_reg, val_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic            get_ok_reg, get_ok_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]   cmp_idx_reg, cmp_idx_next;
    logic            found_reg, found_next;

    logic                  out_vld_reg, out_vld_next;
    logic                  ok_reg, ok_next;
    logic [VALUE_BITS-1:0] elem_reg, elem_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  rej_reg, rej_next;

    logic [EW-1:0] mem [CAPACITY];
    logic [EW-1:0] rd_data_reg;
    logic          mem_re, mem_we;
    logic [AW-1:0] mem_ra, mem_wa;
    logic [EW-1:0] mem_wd;

    logic            issue, match, last_cmp, finish_go;
    op_t             op_in;
    logic [CW+3:0]   pos_wide, cnt_wide;
    logic [CW+4:0]   cnt_out_ext;
    logic [EW+31:0]  elem_ext;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, rej_reg, cnt_reg, elem_reg, ok_reg};

    assign op_in     = s_tdata[2:0];
    assign pos_wide  = (CW+4)'(s_tdata[38:35]);
    assign cnt_wide  = (CW+4)'(count_reg);
    assign issue     = (idx_reg < count_reg);
    assign match     = cmp_vld_reg && (rd_data_reg == val_reg);
    assign last_cmp  = cmp_vld_reg && ((CW'(cmp_idx_reg) + CW'(1)) == count_reg);
    assign finish_go = (state_reg == ST_FINISH) && (!out_vld_reg || m_tready);

    assign cnt_out_ext = (CW+5)'(count_next);
    assign elem_ext    = (EW+32)'(rd_data_reg);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        pos_next     = pos_reg;
        get_ok_next  = get_ok_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        cmp_vld_next = cmp_vld_reg;
        cmp_idx_next = cmp_idx_reg;
        found_next   = found_reg;
        ok_next      = ok_reg;
        elem_next    = elem_reg;
        rej_next     = rej_reg;
        mem_re       = 1'b0;
        mem_ra       = idx_reg[AW-1:0];
        mem_we       = 1'b0;
        mem_wa       = count_reg[AW-1:0];
        mem_wd       = val_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next      = op_in;
                    val_next     = s_tdata[3 +: EW];
                    pos_next     = AW'(s_tdata[38:35]);
                    get_ok_next  = (pos_wide < cnt_wide);
                    found_next   = 1'b0;
                    idx_next     = '0;
                    cmp_vld_next = 1'b0;
                    case (op_in)
                        OP_ADD, OP_CONTAINS, OP_REMOVE:
                            state_next = (count_reg == '0) ? ST_FINISH : ST_SCAN;
                        OP_GET:
                            state_next = (pos_wide < cnt_wide) ? ST_GET : ST_FINISH;
                        default:
                            state_next = ST_FINISH;
                    endcase
                end
            end

            ST_SCAN:
            begin
                // read one entry per cycle; the compare works on the registered read data
                mem_re       = issue;
                cmp_vld_next = issue;
                cmp_idx_next = idx_reg[AW-1:0];
                if (issue)
                    idx_next = idx_reg + CW'(1);
                if (match)
                begin
                    found_next = 1'b1;
                    if (op_reg == OP_REMOVE)
                    begin
                        state_next   = ST_SHIFT;
                        idx_next     = CW'(cmp_idx_reg) + CW'(1);
                        cmp_vld_next = 1'b0;
                    end
                    else
                        state_next = ST_FINISH;
                end
                else if (last_cmp)
                    state_next = ST_FINISH;
            end

            ST_SHIFT:
            begin
                // entry i+1 read, then written back at i
                mem_re       = issue;
                cmp_vld_next = issue;
                cmp_idx_next = idx_reg[AW-1:0];
                if (issue)
                    idx_next = idx_reg + CW'(1);
                if (cmp_vld_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = cmp_idx_reg - AW'(1);
                    mem_wd = rd_data_reg;
                end
                if (!issue && !cmp_vld_reg)
                    state_next = ST_FINISH;
            end

            ST_GET:
            begin
                mem_re     = 1'b1;
                mem_ra     = pos_reg;
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (finish_go)
                begin
                    ok_next    = 1'b0;
                    elem_next  = '0;
                    rej_next   = 1'b0;
                    state_next = ST_IDLE;
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (!found_reg)
                            begin
                                if (count_reg < CW'(CAPACITY))
                                begin
                                    mem_we     = 1'b1;
                                    count_next = count_reg + CW'(1);
                                    ok_next    = 1'b1;
                                end
                                else
                                    rej_next = 1'b1;
                            end
                        end
                        OP_CONTAINS:
                            ok_next = found_reg;
                        OP_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                count_next = count_reg - CW'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        OP_GET:
                        begin
                            if (get_ok_reg)
                            begin
                                ok_next   = 1'b1;
                                elem_next = elem_ext[VALUE_BITS-1:0];
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            ok_next    = 1'b1;
                        end
                        default:
                            ok_next = 1'b0;
                    endcase
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    assign cnt_next = finish_go ? cnt_out_ext[COUNT_BITS-1:0] : cnt_reg;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (finish_go)
            out_vld_next = 1'b1;
        else if (m_tready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            cmp_vld_reg <= cmp_vld_next;
            found_reg   <= found_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        val_reg     <= val_next;
        pos_reg     <= pos_next;
        get_ok_reg  <= get_ok_next;
        cmp_idx_reg <= cmp_idx_next;
        ok_reg      <= ok_next;
        elem_reg    <= elem_next;
        cnt_reg     <= cnt_next;
        rej_reg     <= rej_next;
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= mem[mem_ra];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_ok_rej_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> !(ok_reg && rej_reg))
        else $error("result flags both ok and full_reject");

    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        (finish_go && op_reg == OP_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty the store");

    a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (count_reg != '0) && found_reg)
        else $error("shift running without a matched entry");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CW'(mem_wa) < count_reg || (finish_go && op_reg == OP_ADD)))
        else $error("entry write outside the held range");

endmodule

`default_nettype wire

FILE: verif/insertion_ordered_set_store_test.sv
// Testbench for insertion_ordered_set_store: directed and random set requests,
// checked against an in-bench model of the ordered set. Needs rtl/ios_pkg.sv and
// rtl/insertion_ordered_set_store.sv.
`timescale 1ns / 1ps

module insertion_ordered_set_store_test;
    import ios_pkg::*;

    localparam int CAPACITY = 16;
    localparam int POOL_SIZE = 40;
    localparam int HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 60;

    // spare operation codes, decoded by the block as no-ops
    localparam op_t OP_SPARE_LO = OP_CLEAR + 3'd1;
    localparam op_t OP_SPARE_HI = '1;

    typedef struct packed {
        logic        ok;
        logic [31:0] element;
        logic [4:0]  count;
        logic        full_reject;
    } set_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [TDATA_BITS-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;

    // bench copy of the set
    logic [31:0] set_entries [CAPACITY];
    int set_count = 0;

    set_result_t pending_results [$];
    logic [31:0] value_pool [POOL_SIZE];

    int errors = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int full_rejects = 0;
    int shifting_removes = 0;
    bit idle_enable = 1'b1;
    bit hold_start = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    insertion_ordered_set_store uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    function automatic set_result_t predict_request(op_t op, logic [31:0] value,
                                                    logic [3:0] pos);
        set_result_t r;
        int slot;
        r = '0;
        slot = -1;
        for (int i = 0; i < set_count; i++)
        begin
            if (slot < 0 && set_entries[i] == value)
                slot = i;
        end
        case (op)
            OP_ADD:
            begin
                if (slot < 0)
                begin
                    if (set_count < CAPACITY)
                    begin
                        set_entries[set_count] = value;
                        set_count++;
                        r.ok = 1'b1;
                    end
                    else
                    begin
                        r.full_reject = 1'b1;
                        full_rejects++;
                    end
                end
            end
            OP_CONTAINS:
                r.ok = (slot >= 0);
            OP_REMOVE:
            begin
                if (slot >= 0)
                begin
                    if (slot < set_count - 1)
                        shifting_removes++;
                    for (int i = slot; i < set_count - 1; i++)
                        set_entries[i] = set_entries[i + 1];
                    set_count--;
                    r.ok = 1'b1;
                end
            end
            OP_GET:
            begin
                if (pos < set_count)
                begin
                    r.element = set_entries[pos];
                    r.ok = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                set_count = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.count = set_count[4:0];
        return r;
    endfunction

    task automatic send_request(input op_t op, input logic [31:0] value,
                                input logic [3:0] pos);
        @(negedge clk);
        while (idle_enable && $urandom_range(99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, pos, value, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(predict_request(op, value, pos));
        requests_sent++;
    endtask

    // Random request biased toward values the set holds, so hits and shifts happen.
    task automatic send_random_request();
        int r;
        op_t op;
        logic [31:0] value;
        logic [3:0] pos;
        r = $urandom_range(99);
        if (r < 38)
            op = OP_ADD;
        else if (r < 56)
            op = OP_CONTAINS;
        else if (r < 74)
            op = OP_REMOVE;
        else if (r < 90)
            op = OP_GET;
        else if (r < 97)
            op = (set_count == CAPACITY || r < 93) ? OP_CLEAR : OP_ADD;
        else
            op = op_t'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        if (op != OP_ADD && set_count > 0 && $urandom_range(1) == 1)
            value = set_entries[$urandom_range(set_count - 1)];
        else if ($urandom_range(99) < 85)
            value = value_pool[$urandom_range(POOL_SIZE - 1)];
        else
            value = $urandom;
        if (set_count > 0 && $urandom_range(3) != 0)
            pos = 4'($urandom_range(set_count - 1));
        else
            pos = 4'($urandom_range(15));
        send_request(op, value, pos);
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        $display("%0t mismatch on %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        set_result_t want;
        set_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.ok = m_tdata[0];
            got.element = m_tdata[32:1];
            got.count = m_tdata[37:33];
            got.full_reject = m_tdata[38];
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual 0x%0h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.ok !== want.ok)
                    report_field("ok", 32'(want.ok), 32'(got.ok));
                if (got.element !== want.element)
                    report_field("element", want.element, got.element);
                if (got.count !== want.count)
                    report_field("count", 32'(want.count), 32'(got.count));
                if (got.full_reject !== want.full_reject)
                    report_field("full_reject", 32'(want.full_reject),
                                 32'(got.full_reject));
            end
        end
    end

    // result receiver: random idling, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_start)
        begin
            hold_start = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (idle_enable && $urandom_range(99) < 33)
            m_tready <= 1'b0;
        else
            m_tready <= 1'b1;
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_empty_and_edges();
        send_request(OP_GET, 32'h0, 4'hF);
        send_request(OP_REMOVE, 32'hFFFF_FFFF, 4'h0);
        send_request(OP_ADD, 32'h0000_0000, 4'h0);
        send_request(OP_ADD, 32'hFFFF_FFFF, 4'hF);
        send_request(OP_ADD, 32'h0000_0000, 4'h0);     // duplicate
        send_request(OP_CONTAINS, 32'hFFFF_FFFF, 4'h0);
        send_request(OP_GET, 32'h0, 4'h1);
        for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++)
            send_request(op_t'(c), 32'hFFFF_FFFF, 4'hF);
        send_request(OP_CLEAR, 32'h0, 4'h0);
        send_request(OP_GET, 32'h0, 4'h0);              // stale entry after clear
    endtask

    task automatic test_full_store();
        for (int i = 0; i < CAPACITY; i++)
            send_request(OP_ADD, 32'hA5A5_0000 | i, 4'h0);
        send_request(OP_ADD, 32'h5A5A_FFFF, 4'h0);      // new value, no room
        send_request(OP_ADD, 32'hA5A5_0007, 4'h0);      // duplicate while full
        send_request(OP_GET, 32'h0, 4'hF);
        send_request(OP_REMOVE, 32'hA5A5_0000, 4'h0);   // shifts every later entry
        send_request(OP_GET, 32'h0, 4'h0);
        send_request(OP_REMOVE, 32'hA5A5_000F, 4'h0);   // last entry, no shift
    endtask

    task automatic test_random_traffic(input int n);
        for (int i = 0; i < n; i++)
            send_random_request();
    endtask

    task automatic test_back_to_back(input int n);
        idle_enable = 1'b0;
        for (int i = 0; i < n; i++)
            send_random_request();
        idle_enable = 1'b1;
    endtask

    task automatic test_output_stall();
        @(posedge clk);
        hold_start = 1'b1;
        for (int i = 0; i < 12; i++)
            send_random_request();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_and_edges();
        test_full_store();
        test_random_traffic(250);
        test_back_to_back(150);
        test_output_stall();
        test_random_traffic(200);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d requests, checked %0d results; %0d full rejects, %0d shifting removes.",
                 requests_sent, results_checked, full_rejects, shifting_removes);
        $display("Random idling on both sides, one unthrottled stretch, one %0d-cycle output hold.",
                 HOLD_CYCLES);
        if (errors == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
